FILE: src/nwt_pkg.sv
// Package for the Newick word tokenizer: item structs, result kinds, word modes
// and the special byte codes. No dependencies.
package nwt_pkg;

  localparam int unsigned NWT_FIFO_DEPTH = 4;

  localparam logic [63:0] DELIM_LOW_RST = 64'd864712019176062976;
  localparam logic [63:0] DELIM_HIGH_RST = 64'd0;
  localparam logic [63:0] SPACE_LOW_RST = 64'd4294977024;
  localparam logic [63:0] SPACE_HIGH_RST = 64'd0;

  localparam logic [7:0] QUOTE_CH = 8'h27;
  localparam logic [7:0] OPEN_BR = 8'h5B;
  localparam logic [7:0] CLOSE_BR = 8'h5D;

  localparam logic [7:0] CFG_DELIM_LOW = 8'd0;
  localparam logic [7:0] CFG_DELIM_HIGH = 8'd1;
  localparam logic [7:0] CFG_SPACE_LOW = 8'd2;
  localparam logic [7:0] CFG_SPACE_HIGH = 8'd3;

  typedef enum logic [2:0] {
    K_WORD_BYTE    = 3'd0,
    K_WORD_END     = 3'd1,
    K_DELIM        = 3'd2,
    K_COMMENT_BYTE = 3'd3,
    K_COMMENT_END  = 3'd4,
    K_QUOTE_ERR    = 3'd5,
    K_COMMENT_ERR  = 3'd6,
    K_NO_WORD      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OUT    = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_QUOTE  = 2'd2,
    MODE_AFTERQ = 2'd3
  } word_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       last;
  } out_item_t;

  // results of one input item: count 0..2, first two slots in order
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } step_res_t;

endpackage

FILE: src/nwt_step.sv
// Combinational tokenizer step: classifies one byte against the maps and the
// current word/comment state. Depends on nwt_pkg.
module nwt_step
  import nwt_pkg::*;
(
  input  word_mode_t  mode,
  input  logic        comment_open,
  input  logic [63:0] delim_low,
  input  logic [63:0] delim_high,
  input  logic [63:0] space_low,
  input  logic [63:0] space_high,
  input  in_item_t    item,
  output word_mode_t  mode_nxt,
  output logic        comment_nxt,
  output step_res_t   res
);

  logic [7:0] c;
  logic       is_delim;
  logic       is_space;
  logic       is_quote;
  logic       is_open;
  logic       is_close;

  assign c = item.ch;
  assign is_delim = !c[7] && (c[6] ? delim_high[c[5:0]] : delim_low[c[5:0]]);
  assign is_space = !c[7] && (c[6] ? space_high[c[5:0]] : space_low[c[5:0]]);
  assign is_quote = (c == QUOTE_CH);
  assign is_open = (c == OPEN_BR);
  assign is_close = (c == CLOSE_BR);

  always_comb begin
    kind_t      k0;
    kind_t      k1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
    mode_nxt = mode;
    comment_nxt = comment_open;
    k0 = K_WORD_BYTE;
    k1 = K_WORD_BYTE;
    b0 = 8'd0;
    b1 = 8'd0;
    n = 2'd0;
    if (item.end_of_text) begin
      n = 2'd1;
      if (mode == MODE_QUOTE) begin
        k0 = K_QUOTE_ERR;
      end else if (comment_open) begin
        k0 = K_COMMENT_ERR;
      end else if (mode != MODE_OUT) begin
        k0 = K_WORD_END;
      end else begin
        k0 = K_NO_WORD;
      end
      mode_nxt = MODE_OUT;
      comment_nxt = 1'b0;
    end else if (comment_open) begin
      n = 2'd1;
      if (is_close) begin
        comment_nxt = 1'b0;
        k0 = K_COMMENT_END;
      end else begin
        k0 = K_COMMENT_BYTE;
        b0 = c;
      end
    end else if (mode == MODE_OUT) begin
      // maps take priority over quote and bracket outside a word
      if (is_space) begin
        n = 2'd0;
      end else if (is_delim) begin
        n = 2'd1;
        k0 = K_DELIM;
        b0 = c;
      end else if (is_quote) begin
        mode_nxt = MODE_QUOTE;
        n = 2'd1;
        b0 = c;
      end else if (is_open) begin
        comment_nxt = 1'b1;
      end else begin
        mode_nxt = MODE_WORD;
        n = 2'd1;
        b0 = c;
      end
    end else if (mode == MODE_QUOTE) begin
      if (is_quote) begin
        mode_nxt = MODE_AFTERQ;
      end
      n = 2'd1;
      b0 = c;
    end else if (mode == MODE_AFTERQ && is_quote) begin
      // doubled quote: reopen
      mode_nxt = MODE_QUOTE;
      n = 2'd1;
      b0 = c;
    end else begin
      mode_nxt = MODE_WORD;
      if (is_quote) begin
        // quote opening mid-word is dropped
        mode_nxt = MODE_QUOTE;
      end else if (is_space) begin
        mode_nxt = MODE_OUT;
        n = 2'd1;
        k0 = K_WORD_END;
      end else if (is_delim) begin
        mode_nxt = MODE_OUT;
        n = 2'd2;
        k0 = K_WORD_END;
        k1 = K_DELIM;
        b1 = c;
      end else if (is_open) begin
        comment_nxt = 1'b1;
      end else begin
        n = 2'd1;
        b0 = c;
      end
    end
    res.cnt = n;
    res.r0.kind = k0;
    res.r0.byte_out = b0;
    res.r0.last = (n == 2'd1);
    res.r1.kind = k1;
    res.r1.byte_out = b1;
    res.r1.last = 1'b1;
  end

endmodule

FILE: src/nwt_res_fifo.sv
// Result queue: takes up to two result items per cycle and hands out one.
// Depth must be a power of two of at least 2. Depends on nwt_pkg.
module nwt_res_fifo
  import nwt_pkg::*;
#(
  parameter int unsigned Depth = NWT_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  step_res_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] AcceptMax = CntW'(Depth - 2);

  out_item_t         mem [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [PtrW-1:0]   rd_ptr_nxt;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   count_nxt;
  logic              pop;

  assign room = (count_r <= AcceptMax);
  assign out_valid = (count_r != '0);
  assign out_data = mem[rd_ptr_r];
  assign pop = out_valid && !out_stall;

  assign wr_ptr_nxt = wr_ptr_r + PtrW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
  assign count_nxt = count_r + CntW'(push.cnt) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + PtrW'(1)] <= push.r1;
    end
  end

endmodule

FILE: src/newick_word_tokenizer_core.sv
// Newick word tokenizer top level: configuration maps, word/comment state,
// step logic and result queue. Depends on nwt_pkg, nwt_step, nwt_res_fifo.
//
// Usage: feed one text byte per item on in_data (or an item with end_of_text
// set to close the text). Each item yields zero, one or two result items on
// out_data; the last result of an item carries last = 1. Skipped whitespace,
// a bracket opening a comment and a mid-word quote yield nothing.
// A result is written to the queue when its item is accepted and is offered once the results ahead of it are taken.
// Throughput: one item per cycle as long as the queue is drained; an item
// that ends a word on a delimiter yields two results, so the output
// side (one result per unstalled cycle) bounds the sustained rate.
// in_stall rises when the FifoDepth-entry result queue has fewer than two
// free slots; out_stall simply holds the head result until taken.
// Reset (rst_n low, synchronous) empties the queue, leaves word and comment
// state cleared and loads the default delimiter and whitespace maps.
// cfg_we writes map cfg_index (0..3); other indexes are ignored.
module newick_word_tokenizer_core
  import nwt_pkg::*;
#(
  parameter int unsigned FifoDepth = NWT_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] delim_low_r;
  logic [63:0] delim_high_r;
  logic [63:0] space_low_r;
  logic [63:0] space_high_r;
  word_mode_t  mode_r;
  word_mode_t  mode_nxt;
  logic        comment_r;
  logic        comment_nxt;
  step_res_t   step_res;
  step_res_t   push;
  logic        room;
  logic        in_acc;

  assign in_stall = !room;
  assign in_acc = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_low_r <= DELIM_LOW_RST;
      delim_high_r <= DELIM_HIGH_RST;
      space_low_r <= SPACE_LOW_RST;
      space_high_r <= SPACE_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DELIM_LOW) delim_low_r <= cfg_wdata;
      if (cfg_index == CFG_DELIM_HIGH) delim_high_r <= cfg_wdata;
      if (cfg_index == CFG_SPACE_LOW) space_low_r <= cfg_wdata;
      if (cfg_index == CFG_SPACE_HIGH) space_high_r <= cfg_wdata;
    end
  end

  nwt_step u_step (
    .mode         (mode_r),
    .comment_open (comment_r),
    .delim_low    (delim_low_r),
    .delim_high   (delim_high_r),
    .space_low    (space_low_r),
    .space_high   (space_high_r),
    .item         (in_data),
    .mode_nxt     (mode_nxt),
    .comment_nxt  (comment_nxt),
    .res          (step_res)
  );

  // hold state unless an item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OUT;
      comment_r <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      comment_r <= comment_nxt;
    end
  end

  always_comb begin
    push = step_res;
    if (!in_acc) begin
      push.cnt = 2'd0;
    end
  end

  nwt_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
